[hdl/lfu_pkg.sv]
// Package for the LFU cache: defaults, word types, status codes, sequencer states.
// No dependencies.
package lfu_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 16;
	localparam int unsigned COUNT_BITS_DEF  = 32;
	localparam int unsigned CAP_BITS        = 5;

	localparam logic [1:0] STATUS_SET_DONE = 2'd0;
	localparam logic [1:0] STATUS_GET_HIT  = 2'd1;
	localparam logic [1:0] STATUS_GET_MISS = 2'd2;

	localparam logic ACTION_GET = 1'b0;
	localparam logic ACTION_SET = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] key;
		logic [63:0] value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] read_value;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EV_A,
		ST_EV_B,
		ST_DN_L,
		ST_DN_R,
		ST_DN_C,
		ST_UP_A,
		ST_UP_C,
		ST_DONE
	} state_t;

endpackage

[hdl/lfu_cache_min_heap_unit.sv]
// LFU cache with use counts in a binary min-heap held in one synchronous memory.
// Depends on lfu_pkg.
//
// One word is handled at a time. The key scan reads one entry a cycle until a hit or
// the end of the occupied entries. A sift-down reads the left and the right child and
// compares at each level, and a sift-up reads the parent and compares at each level.
// A set that evicts moves the last entry to the root and sifts it down, for each evicted
// entry; a lowered capacity can make one set evict several entries. The result is then
// posted, and the next word is taken while the previous result waits in the output
// register.
module lfu_cache_min_heap_unit
	import lfu_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_word_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_word_t           out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CAP_BITS-1:0] cfg_data
);

	localparam int unsigned IW = $clog2(MAX_ENTRIES);
	localparam int unsigned OW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned CW = IW + 2;
	localparam int unsigned KW = (CW > CAP_BITS) ? CW : CAP_BITS + 1;

	typedef struct packed {
		logic [31:0]           key;
		logic [COUNT_BITS-1:0] count;
		logic [63:0]           value;
	} entry_t;

	entry_t mem [MAX_ENTRIES];
	entry_t rdata_q;
	logic            rd_en, we;
	logic [IW-1:0]   raddr, waddr;
	entry_t          wdata;

	state_t state_q, state_d;
	in_word_t in_q;
	entry_t cur_q, lft_q, cur_inc;
	logic [IW-1:0] i_q, pidx_s1;
	logic pend_s1, evict_q;
	logic [OW-1:0] occ_q, scan_q;
	logic [CAP_BITS-1:0] cap_q;
	out_word_t res_q;
	out_word_t pend_q;
	logic out_valid_q;

	logic hit, scan_more, ev_need, dn_stop, up_swap, l_lt, r_lt, r_ok;
	logic [CW-1:0] l_idx, r_idx, occ_x, s_idx;
	logic [KW-1:0] cap_eff, occ_k;
	logic [IW-1:0] p_idx;
	entry_t best;

	always_comb begin
		occ_x   = CW'(occ_q);
		occ_k   = KW'(occ_q);
		l_idx   = {1'b0, i_q, 1'b1};
		r_idx   = CW'({i_q, 1'b0}) + CW'(2);
		r_ok    = r_idx < occ_x;
		p_idx   = (i_q - IW'(1)) >> 1;
		hit     = pend_s1 && (rdata_q.key == in_q.key);
		scan_more = scan_q < occ_q;
		if (cap_q == '0) begin
			cap_eff = KW'(1);
		end else if (KW'(cap_q) > KW'(MAX_ENTRIES)) begin
			cap_eff = KW'(MAX_ENTRIES);
		end else begin
			cap_eff = KW'(cap_q);
		end
		ev_need = (occ_k >= cap_eff) && (occ_q != '0);
		dn_stop = l_idx >= occ_x;
		l_lt    = lft_q.count < cur_q.count;
		best    = l_lt ? lft_q : cur_q;
		s_idx   = l_lt ? l_idx : CW'(i_q);
		r_lt    = r_ok && (rdata_q.count < best.count);
		if (r_lt) begin
			best  = rdata_q;
			s_idx = r_idx;
		end
		up_swap = rdata_q.count > cur_q.count;
		cur_inc = rdata_q;
		if (rdata_q.count != '1) begin
			cur_inc.count = rdata_q.count + COUNT_BITS'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (hit) begin
					if (in_q.action == ACTION_SET && rdata_q.value != in_q.value) begin
						state_d = ST_UP_A;
					end else begin
						state_d = ST_DN_L;
					end
				end else if (!scan_more) begin
					state_d = (in_q.action == ACTION_SET) ? ST_EV_A : ST_DONE;
				end
			end
			ST_EV_A: state_d = ev_need ? ST_EV_B : ST_UP_A;
			ST_EV_B: state_d = ST_DN_L;
			ST_DN_L: begin
				if (dn_stop) state_d = evict_q ? ST_EV_A : ST_DONE;
				else state_d = ST_DN_R;
			end
			ST_DN_R: state_d = ST_DN_C;
			ST_DN_C: begin
				if (s_idx == CW'(i_q)) state_d = evict_q ? ST_EV_A : ST_DONE;
				else state_d = ST_DN_L;
			end
			ST_UP_A: state_d = (i_q == '0) ? ST_DONE : ST_UP_C;
			ST_UP_C: state_d = up_swap ? ST_UP_A : ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = i_q;
		wdata = cur_q;
		unique case (state_q)
			ST_SCAN: begin
				rd_en = !hit && scan_more;
				raddr = scan_q[IW-1:0];
			end
			ST_EV_A: begin
				rd_en = ev_need;
				raddr = IW'(occ_q - OW'(1));
			end
			ST_DN_L: begin
				rd_en = !dn_stop;
				raddr = l_idx[IW-1:0];
				we    = dn_stop;
			end
			ST_DN_R: begin
				rd_en = r_ok;
				raddr = r_idx[IW-1:0];
			end
			ST_DN_C: begin
				we    = 1'b1;
				wdata = best;
			end
			ST_UP_A: begin
				rd_en = i_q != '0;
				raddr = p_idx;
				we    = i_q == '0;
			end
			ST_UP_C: begin
				we    = 1'b1;
				wdata = up_swap ? rdata_q : cur_q;
			end
			default: ;
		endcase
	end

	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (rd_en) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			cap_q       <= CAP_BITS'(16);
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
			scan_q      <= '0;
			evict_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) cap_q <= cfg_data;
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			pend_s1 <= rd_en && state_q == ST_SCAN;
			unique case (state_q)
				ST_IDLE: begin
					scan_q  <= '0;
					evict_q <= 1'b0;
				end
				ST_SCAN: begin
					if (rd_en) scan_q <= scan_q + OW'(1);
				end
				ST_EV_A: begin
					evict_q <= ev_need;
					if (ev_need) occ_q <= occ_q - OW'(1);
					else occ_q <= occ_q + OW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en && state_q == ST_SCAN) pidx_s1 <= scan_q[IW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) in_q <= in_data;
			end
			ST_SCAN: begin
				if (hit) begin
					i_q <= pidx_s1;
					if (in_q.action == ACTION_SET && rdata_q.value != in_q.value) begin
						cur_q  <= '{key: in_q.key, count: COUNT_BITS'(1), value: in_q.value};
						pend_q <= '{status: STATUS_SET_DONE, read_value: '0};
					end else begin
						cur_q  <= cur_inc;
						pend_q <= (in_q.action == ACTION_GET)
							? '{status: STATUS_GET_HIT, read_value: rdata_q.value}
							: '{status: STATUS_SET_DONE, read_value: 64'd0};
					end
				end else if (!scan_more) begin
					pend_q <= (in_q.action == ACTION_GET)
						? '{status: STATUS_GET_MISS, read_value: 64'd0}
						: '{status: STATUS_SET_DONE, read_value: 64'd0};
				end
			end
			ST_EV_A: begin
				if (!ev_need) begin
					i_q   <= IW'(occ_q);
					cur_q <= '{key: in_q.key, count: COUNT_BITS'(1), value: in_q.value};
				end
			end
			ST_EV_B: begin
				cur_q <= rdata_q;
				i_q   <= '0;
			end
			ST_DN_R: lft_q <= rdata_q;
			ST_DN_C: i_q <= s_idx[IW-1:0];
			ST_UP_C: begin
				if (up_swap) i_q <= p_idx;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) res_q <= pend_q;
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(MAX_ENTRIES))
		else $error("occupancy above depth");
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (occ_q == $past(occ_q) || occ_q == $past(occ_q) + OW'(1)
			|| occ_q == $past(occ_q) - OW'(1)))
		else $error("occupancy jumped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SCAN)
		else $error("accepted word not scanned");
	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && rd_en |-> OW'(raddr) < occ_q)
		else $error("scan read beyond occupancy");
	a_write_addr: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (OW'(waddr) < occ_q) || (waddr == '0))
		else $error("write beyond occupancy");
`endif

endmodule

[bench/lfu_cache_min_heap_unit_tb.sv]
// Self-checking bench for lfu_cache_min_heap_unit: directed table plus random gets/sets,
// checked against an in-bench LFU min-heap predictor across several capacity settings.
// Depends on lfu_pkg and the unit itself.
module lfu_cache_min_heap_unit_tb;
	import lfu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int RAND_PER_PHASE = 170;
	localparam int NUM_PHASES = 8;

	typedef struct packed {
		logic        act;
		logic [31:0] key;
		logic [63:0] val;
		logic        chk;
		logic [1:0]  st;
		logic [63:0] rv;
	} dir_row_t;

	localparam int DIR_LEN = 20;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam dir_row_t DIR_TAB [DIR_LEN] = '{
		'{ACTION_GET, 32'h0, 64'h0, 1'b1, STATUS_GET_MISS, 64'h0},
		'{ACTION_SET, 32'h0, ONES, 1'b1, STATUS_SET_DONE, 64'h0},
		'{ACTION_GET, 32'h0, 64'h0, 1'b1, STATUS_GET_HIT, ONES},
		'{ACTION_SET, 32'hFFFF_FFFF, 64'h0, 1'b1, STATUS_SET_DONE, 64'h0},
		'{ACTION_GET, 32'hFFFF_FFFF, ONES, 1'b1, STATUS_GET_HIT, 64'h0},
		'{ACTION_SET, 32'h0, ONES, 1'b0, 2'd0, 64'h0},
		'{ACTION_SET, 32'h0, 64'h5555_AAAA_5555_AAAA, 1'b0, 2'd0, 64'h0},
		'{ACTION_GET, 32'h0, 64'h0, 1'b0, 2'd0, 64'h0},
		'{ACTION_SET, 32'h1, 64'h1, 1'b0, 2'd0, 64'h0},
		'{ACTION_SET, 32'h2, 64'h2, 1'b0, 2'd0, 64'h0},
		'{ACTION_SET, 32'h3, 64'h3, 1'b0, 2'd0, 64'h0},
		'{ACTION_GET, 32'h5, 64'h0, 1'b1, STATUS_GET_MISS, 64'h0},
		'{ACTION_GET, 32'h3, 64'h0, 1'b0, 2'd0, 64'h0},
		'{ACTION_GET, 32'h3, 64'h0, 1'b0, 2'd0, 64'h0},
		'{ACTION_GET, 32'h1, 64'h0, 1'b0, 2'd0, 64'h0},
		'{ACTION_SET, 32'h2, 64'h2, 1'b0, 2'd0, 64'h0},
		'{ACTION_SET, 32'h8000_0000, 64'h8000_0000_0000_0000, 1'b0, 2'd0, 64'h0},
		'{ACTION_GET, 32'h8000_0000, 64'h0, 1'b0, 2'd0, 64'h0},
		'{ACTION_GET, 32'h2, 64'h0, 1'b0, 2'd0, 64'h0},
		'{ACTION_GET, 32'hFFFF_FFFF, 64'h0, 1'b0, 2'd0, 64'h0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CAP_BITS-1:0] cfg_data = '0;

	always #5 clk = ~clk;

	lfu_cache_min_heap_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] lfu_key [DEPTH];
	logic [31:0] lfu_cnt [DEPTH];
	logic [63:0] lfu_val [DEPTH];
	int unsigned lfu_occ = 0;
	int unsigned lfu_cap = 16;

	out_word_t expected_words [$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int hits_seen = 0;
	logic drv_chk = 1'b0;
	out_word_t drv_exp = '0;

	function automatic void slot_swap(int unsigned a, int unsigned b);
		logic [31:0] k, c;
		logic [63:0] v;
		k = lfu_key[a]; c = lfu_cnt[a]; v = lfu_val[a];
		lfu_key[a] = lfu_key[b]; lfu_cnt[a] = lfu_cnt[b]; lfu_val[a] = lfu_val[b];
		lfu_key[b] = k; lfu_cnt[b] = c; lfu_val[b] = v;
	endfunction

	function automatic void heap_down(int unsigned i);
		int unsigned l, r, s;
		while (i < lfu_occ) begin
			l = 2 * i + 1;
			r = 2 * i + 2;
			s = i;
			if (l < lfu_occ && lfu_cnt[l] < lfu_cnt[s]) s = l;
			if (r < lfu_occ && lfu_cnt[r] < lfu_cnt[s]) s = r;
			if (s == i) break;
			slot_swap(i, s);
			i = s;
		end
	endfunction

	function automatic void heap_up(int unsigned i);
		int unsigned p;
		while (i > 0 && i < lfu_occ) begin
			p = (i - 1) / 2;
			if (!(lfu_cnt[p] > lfu_cnt[i])) break;
			slot_swap(i, p);
			i = p;
		end
	endfunction

	function automatic void bump_use(int unsigned i);
		if (lfu_cnt[i] != 32'hFFFF_FFFF) lfu_cnt[i] = lfu_cnt[i] + 32'd1;
		heap_down(i);
	endfunction

	function automatic out_word_t lfu_access(in_word_t w);
		out_word_t r;
		int unsigned pos, cap;
		bit hit;
		hit = 0;
		pos = 0;
		r = '0;
		for (int unsigned i = 0; i < lfu_occ; i++)
			if (!hit && lfu_key[i] == w.key) begin
				hit = 1;
				pos = i;
			end
		if (w.action == ACTION_GET) begin
			if (hit) begin
				r.status = STATUS_GET_HIT;
				r.read_value = lfu_val[pos];
				bump_use(pos);
			end else
				r.status = STATUS_GET_MISS;
			return r;
		end
		r.status = STATUS_SET_DONE;
		if (hit) begin
			if (lfu_val[pos] == w.value)
				bump_use(pos);
			else begin
				lfu_val[pos] = w.value;
				lfu_cnt[pos] = 32'd1;
				heap_up(pos);
			end
		end else begin
			cap = (lfu_cap < 1) ? 1 : (lfu_cap > DEPTH) ? DEPTH : lfu_cap;
			while (lfu_occ >= cap && lfu_occ > 0) begin
				lfu_occ--;
				lfu_key[0] = lfu_key[lfu_occ];
				lfu_cnt[0] = lfu_cnt[lfu_occ];
				lfu_val[0] = lfu_val[lfu_occ];
				heap_down(0);
			end
			pos = lfu_occ;
			lfu_key[pos] = w.key;
			lfu_cnt[pos] = 32'd1;
			lfu_val[pos] = w.value;
			lfu_occ++;
			heap_up(pos);
		end
		return r;
	endfunction

	// receiver stall pattern: alternating free-running and throttled stretches
	int stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= (stall_phase + 1) % 600;
		if (stall_phase < 200)
			out_ready <= 1'b1;
		else if (stall_phase < 400)
			out_ready <= ($urandom_range(0, 3) != 0);
		else
			out_ready <= ($urandom_range(0, 7) == 0);
	end

	// scoreboard
	always @(posedge clk) begin
		out_word_t exp_w, pred;
		if (out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				if (errors < 10) $display("ERROR: unexpected word %h", out_data);
				errors++;
			end else begin
				exp_w = expected_words.pop_front();
				words_checked++;
				if (out_data.status == STATUS_GET_HIT) hits_seen++;
				if (out_data.status !== exp_w.status
						|| out_data.read_value !== exp_w.read_value) begin
					if (errors < 10)
						$display("ERROR: word %0d status exp %0d got %0d, value exp %h got %h",
							words_checked, exp_w.status, out_data.status,
							exp_w.read_value, out_data.read_value);
					errors++;
				end
			end
		end
		if (in_valid && in_ready) begin
			pred = lfu_access(in_data);
			expected_words.push_back(drv_chk ? drv_exp : pred);
		end
	end

	int burst_left = 0;

	task automatic send_word(in_word_t w, logic chk, out_word_t ex);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= w;
		drv_chk <= chk;
		drv_exp <= ex;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_BITS-1:0] c);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		lfu_cap = c;
	endtask

	function automatic in_word_t random_word();
		in_word_t w;
		int sel;
		w.action = 1'($urandom_range(0, 1));
		sel = $urandom_range(0, 9);
		if (sel < 8)
			w.key = 32'($urandom_range(0, 23)) ^ 32'hA5A5_0000;
		else if (sel == 8)
			w.key = 32'hFFFF_FFFF;
		else
			w.key = $urandom;
		if ($urandom_range(0, 1))
			w.value = {w.key, 32'($urandom_range(0, 2))};
		else
			w.value = {$urandom, $urandom};
		return w;
	endfunction

	localparam logic [CAP_BITS-1:0] CAP_PLAN [NUM_PHASES] =
		'{5'd16, 5'd0, 5'd1, 5'd31, 5'd2, 5'd5, 5'd17, 5'd9};

	initial begin
		in_word_t w;
		out_word_t ex;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int i = 0; i < DIR_LEN; i++) begin
			w.action = DIR_TAB[i].act;
			w.key = DIR_TAB[i].key;
			w.value = DIR_TAB[i].val;
			ex.status = DIR_TAB[i].st;
			ex.read_value = DIR_TAB[i].rv;
			send_word(w, DIR_TAB[i].chk, ex);
		end
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			if (ph > 0) write_capacity(CAP_PLAN[ph]);
			else if ($urandom_range(0, 1)) write_capacity(5'd16);
			for (int n = 0; n < RAND_PER_PHASE; n++)
				send_word(random_word(), 1'b0, '0);
		end
		drain();
		if (expected_words.size() != 0) errors++;
		$display("Ran %0d words (%0d checked, %0d hits) over %0d capacity settings.",
			words_sent, words_checked, hits_seen, NUM_PHASES);
		if (errors == 0)
			$display("Test completed successfully");
		else begin
			$display("%0d mismatches", errors);
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d words outstanding", expected_words.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
